>>> hdl/blmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blmt_pkg
// Types and constants for the button long-press and multi-tap unit.
// ----------------------------------------------------------------------------
package blmt_pkg;

    localparam int unsigned TIME_W      = 48;
    localparam int unsigned HOLD_W      = 5;
    localparam int unsigned TAP_W       = 3;
    localparam int unsigned WINDOW_W    = 24;
    localparam int unsigned APB_AW      = 4;
    localparam int unsigned APB_DW      = 32;

    // register indexes on the configuration port
    localparam logic [1:0] REG_IO_PRESENT      = 2'd0;
    localparam logic [1:0] REG_HOLD_TICKS      = 2'd1;
    localparam logic [1:0] REG_PAIRING_PRESSES = 2'd2;
    localparam logic [1:0] REG_WINDOW_US       = 2'd3;

    localparam logic                RESET_IO_PRESENT      = 1'b0;
    localparam logic [HOLD_W-1:0]   RESET_HOLD_TICKS      = 5'd30;
    localparam logic [TAP_W-1:0]    RESET_PAIRING_PRESSES = 3'd3;
    localparam logic [WINDOW_W-1:0] RESET_WINDOW_US       = 24'd2000000;

    localparam logic [HOLD_W-1:0]   HOLD_MAX = 5'd31;

    // blink step is kept as pattern bit index and a sub-step of three ticks
    localparam logic [1:0] BLINK_SUB_LAST = 2'd2;
    localparam logic [3:0] BLINK_IDX_LAST = 4'd15;

    localparam logic [15:0] PAT_PRESSED_ARMED   = 16'hffff;
    localparam logic [15:0] PAT_PRESSED_SAFE    = 16'h5050;
    localparam logic [15:0] PAT_RELEASED_ARMED  = 16'h5500;
    localparam logic [15:0] PAT_RELEASED_SAFE   = 16'h0003;

    typedef struct packed {
        logic              button_level;
        logic [TIME_W-1:0] time_us;
        logic              armed_valid;
        logic              armed_flag;
    } in_item_t;

    typedef struct packed {
        logic long_press_event;
        logic multi_tap_event;
        logic led_write;
        logic led_drive;
    } out_item_t;

    function automatic logic [15:0] blink_pattern(input logic pressed, input logic armed);
        logic [15:0] pat;
        case ({pressed, armed})
            2'b11:   pat = PAT_PRESSED_ARMED;
            2'b10:   pat = PAT_PRESSED_SAFE;
            2'b01:   pat = PAT_RELEASED_ARMED;
            default: pat = PAT_RELEASED_SAFE;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

>>> hdl/button_long_press_and_multi_tap_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_long_press_and_multi_tap_unit
// Per-tick button long-press and multi-tap detector with arm-status blink LED.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_data   (in_item_t)
// out       output     out_valid / out_ready out_data  (out_item_t)
// apb       input      psel/penable/pready   paddr, pwdata, prdata
//
// one tick per cycle sustained while out_ready is high; a tick's result is valid
// once the result register loads it (input register loads at the transfer first)
// all tick state updates in the single pass between the two registers
// out_ready low holds the result register; the input register still takes
// one more tick, then in_ready drops
// rst_n clears the control state and loads the register reset values
module button_long_press_and_multi_tap_unit
    import blmt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    // configuration
    logic                io_present_reg;
    logic [HOLD_W-1:0]   hold_ticks_reg;
    logic [TAP_W-1:0]    pairing_presses_reg;
    logic [WINDOW_W-1:0] window_us_reg;

    // tick state
    logic [HOLD_W-1:0]   hold_count_reg, hold_count_next;
    logic [TAP_W-1:0]    tap_count_reg, tap_count_next;
    logic [TIME_W-1:0]   window_start_reg, window_start_next;
    logic                last_button_reg;
    logic [1:0]          blink_sub_reg, blink_sub_next;
    logic [3:0]          blink_idx_reg, blink_idx_next;

    // pipeline
    logic      in_vld_reg;
    in_item_t  in_item_reg;
    logic      out_vld_reg;
    out_item_t out_item_reg, out_item_next;
    logic      advance;

    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [15:0]       pattern;
    logic [HOLD_W-1:0] hold_inc;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    logic              rising;
    logic [TAP_W-1:0]  tap_base;
    logic              tap_hit;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            REG_IO_PRESENT:      prdata = {{(APB_DW-1){1'b0}}, io_present_reg};
            REG_HOLD_TICKS:      prdata = {{(APB_DW-HOLD_W){1'b0}}, hold_ticks_reg};
            REG_PAIRING_PRESSES: prdata = {{(APB_DW-TAP_W){1'b0}}, pairing_presses_reg};
            REG_WINDOW_US:       prdata = {{(APB_DW-WINDOW_W){1'b0}}, window_us_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_present_reg      <= RESET_IO_PRESENT;
            hold_ticks_reg      <= RESET_HOLD_TICKS;
            pairing_presses_reg <= RESET_PAIRING_PRESSES;
            window_us_reg       <= RESET_WINDOW_US;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IO_PRESENT:      io_present_reg      <= pwdata[0];
                REG_HOLD_TICKS:      hold_ticks_reg      <= pwdata[HOLD_W-1:0];
                REG_PAIRING_PRESSES: pairing_presses_reg <= pwdata[TAP_W-1:0];
                REG_WINDOW_US:       window_us_reg       <= pwdata[WINDOW_W-1:0];
                default:             ;
            endcase
        end
    end

    // handshake
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

    // single pass over one tick
    always_comb
    begin
        hold_count_next   = hold_count_reg;
        tap_count_next    = tap_count_reg;
        window_start_next = window_start_reg;
        blink_sub_next    = blink_sub_reg;
        blink_idx_next    = blink_idx_reg;
        out_item_next     = '0;

        pattern  = blink_pattern(last_button_reg, in_item_reg.armed_flag);
        hold_inc = hold_count_reg + 1'b1;

        if (!io_present_reg)
        begin
            if (in_item_reg.armed_valid)
            begin
                out_item_next.led_write = 1'b1;
                out_item_next.led_drive = !pattern[blink_idx_reg];
                if (blink_idx_reg == BLINK_IDX_LAST)
                begin
                    blink_sub_next = '0;
                    blink_idx_next = '0;
                end
                else if (blink_sub_reg == BLINK_SUB_LAST)
                begin
                    blink_sub_next = '0;
                    blink_idx_next = blink_idx_reg + 1'b1;
                end
                else
                begin
                    blink_sub_next = blink_sub_reg + 1'b1;
                end
            end
            if (in_item_reg.button_level)
            begin
                if (hold_count_reg <= hold_ticks_reg && hold_count_reg != HOLD_MAX)
                begin
                    hold_count_next = hold_inc;
                    out_item_next.long_press_event = (hold_inc == hold_ticks_reg);
                end
            end
            else
            begin
                hold_count_next = '0;
            end
        end

        // window expiry is checked before this tick's edge counts
        elapsed = in_item_reg.time_us - window_start_reg;
        expired = elapsed > {{(TIME_W-WINDOW_W){1'b0}}, window_us_reg};
        rising  = !last_button_reg && in_item_reg.button_level;

        tap_base = expired ? '0 : tap_count_reg;
        if (expired)
            window_start_next = '0;
        if (rising)
        begin
            if (window_start_next == '0)
                window_start_next = in_item_reg.time_us;
            tap_count_next = tap_base + 1'b1;
        end
        else
        begin
            tap_count_next = tap_base;
        end

        tap_hit = (tap_count_next == pairing_presses_reg);
        if (tap_hit)
        begin
            out_item_next.multi_tap_event = 1'b1;
            window_start_next = '0;
            tap_count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            hold_count_reg   <= '0;
            tap_count_reg    <= '0;
            window_start_reg <= '0;
            last_button_reg  <= 1'b0;
            blink_sub_reg    <= '0;
            blink_idx_reg    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;

            if (advance)
            begin
                hold_count_reg   <= hold_count_next;
                tap_count_reg    <= tap_count_next;
                window_start_reg <= window_start_next;
                last_button_reg  <= in_item_reg.button_level;
                blink_sub_reg    <= blink_sub_next;
                blink_idx_reg    <= blink_idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= out_item_next;
    end

    // assertions
    a_tap_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && out_item_next.multi_tap_event |=>
            tap_count_reg == '0 && window_start_reg == '0)
        else $error("tap state not cleared after multi-tap transfer");

    a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
        blink_sub_reg != 2'd3 && (blink_idx_reg != BLINK_IDX_LAST || blink_sub_reg == '0))
        else $error("blink step out of range");

    a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        advance && io_present_reg |=> $stable(hold_count_reg) && $stable(blink_idx_reg))
        else $error("hold or blink state moved while io_present set");

    a_no_stall_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |=> out_vld_reg)
        else $error("result dropped while output stalled");

endmodule
`default_nettype wire
